// ===== sv/ac2_pkg.sv =====
// Shared widths, fixed-point constants and types of the arc tangent pipeline.
// Depends on nothing; every other file uses it through scoped names.
package ac2_pkg;

  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 13;

  // Ratio and polynomial formats (Q1.15)
  localparam int Q_FRAC = 15;
  localparam int T_W    = Q_FRAC + 1;
  localparam int ACC_W  = Q_FRAC + 2;
  localparam int PROD_W = 2 * ACC_W;

  // Divider chain: one quotient bit per cell
  localparam int MAG_W  = COORD_BITS;
  localparam int REM_W  = MAG_W + 1;
  localparam int DIV_N  = T_W;

  // Polynomial chain: t*t, four Horner steps, final product with t
  localparam int MAC_N  = 6;

  // Output formats
  localparam int OUT_W  = 16;
  localparam int ANG_W  = ANGLE_FRAC_BITS + 4;
  localparam int WIDE_W = ACC_W + Q_FRAC;
  localparam int SAT_W  = ANG_W + OUT_W;

  localparam int SH_L = (ANGLE_FRAC_BITS >= Q_FRAC) ? ANGLE_FRAC_BITS - Q_FRAC : 0;
  localparam int SH_R = (ANGLE_FRAC_BITS <  Q_FRAC) ? Q_FRAC - ANGLE_FRAC_BITS : 0;
  localparam logic [WIDE_W-1:0] R_RND = (WIDE_W'(1) << SH_R) >> 1;

  // pi rounded to nearest from a 60-fraction-bit value
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam int          PI_SH     = 60 - ANGLE_FRAC_BITS;
  localparam logic [63:0] PI_FULL   = (PI_Q60 + ((64'd1 << PI_SH) >> 1)) >> PI_SH;
  localparam logic [63:0] HALF_FULL = (PI_Q60 + ((64'd1 << (PI_SH + 1)) >> 1)) >> (PI_SH + 1);
  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(PI_FULL);
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(HALF_FULL);

  localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [SAT_W-1:0] OUT_MIN = -OUT_MAX - SAT_W'(1);

  // Bounds of a delivered angle, after saturation
  localparam logic signed [OUT_W-1:0] ANGLE_MAX =
    (PI_FULL > 64'd32767) ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(PI_FULL);
  localparam logic signed [OUT_W-1:0] ANGLE_MIN =
    (PI_FULL > 64'd32767) ? {1'b1, {(OUT_W-1){1'b0}}} : -ANGLE_MAX;

  // Minimax coefficients in Q1.15
  localparam logic signed [ACC_W-1:0] C0 = ACC_W'(32764);
  localparam logic signed [ACC_W-1:0] C1 = -ACC_W'(10823);
  localparam logic signed [ACC_W-1:0] C2 = ACC_W'(5903);
  localparam logic signed [ACC_W-1:0] C3 = -ACC_W'(2790);
  localparam logic signed [ACC_W-1:0] C4 = ACC_W'(683);

  // Constant added after each product of the polynomial chain
  localparam logic signed [ACC_W-1:0] MAC_COEF [MAC_N] = '{'0, C3, C2, C1, C0, '0};

  // Quadrant and special-case flags that travel with a transaction
  typedef struct packed {
    logic x_zero;
    logic y_pos;
    logic y_neg;
    logic x_neg;
    logic fold;
    logic neg;
  } side_t;

endpackage

// ===== sv/ac2_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of min*2^15/max.
// Depends on ac2_pkg for widths and the side flag struct.
module ac2_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [ac2_pkg::REM_W-1:0] rem_i,
  input  logic [ac2_pkg::MAG_W-1:0] div_i,
  input  logic [ac2_pkg::T_W-1:0]   quo_i,
  input  ac2_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [ac2_pkg::REM_W-1:0] rem_o,
  output logic [ac2_pkg::MAG_W-1:0] div_o,
  output logic [ac2_pkg::T_W-1:0]   quo_o,
  output ac2_pkg::side_t            side_o
);

  logic                      valid_q;
  logic [ac2_pkg::REM_W-1:0] rem_q, rem_d;
  logic [ac2_pkg::MAG_W-1:0] div_q;
  logic [ac2_pkg::T_W-1:0]   quo_q, quo_d;
  ac2_pkg::side_t            side_q;
  logic                      ge;
  logic [ac2_pkg::REM_W-1:0] diff;
  logic [ac2_pkg::REM_W-1:0] kept;

  always_comb begin
    ge    = rem_i >= {1'b0, div_i};
    diff  = rem_i - {1'b0, div_i};
    kept  = ge ? diff : rem_i;
    // remainder stays below the divisor, so the shift loses nothing
    rem_d = {kept[ac2_pkg::REM_W-2:0], 1'b0};
    quo_d = {quo_i[ac2_pkg::T_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// ===== sv/ac2_mac_cell.sv =====
// One polynomial cell: registered Q1.15 product, then rounding and a constant add.
// Depends on ac2_pkg for widths and the side flag struct.
module ac2_mac_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [ac2_pkg::ACC_W-1:0] acc_i,
  input  logic signed [ac2_pkg::ACC_W-1:0] mul_i,
  input  logic signed [ac2_pkg::ACC_W-1:0] t_i,
  input  logic signed [ac2_pkg::ACC_W-1:0] coef_i,
  input  ac2_pkg::side_t                   side_i,
  output logic                             valid_o,
  output logic signed [ac2_pkg::ACC_W-1:0] acc_o,
  output logic signed [ac2_pkg::ACC_W-1:0] mul_o,
  output logic signed [ac2_pkg::ACC_W-1:0] t_o,
  output ac2_pkg::side_t                   side_o
);

  localparam logic [ac2_pkg::PROD_W-1:0] HALF = ac2_pkg::PROD_W'(1) << (ac2_pkg::Q_FRAC - 1);

  logic                              va_q, vb_q;
  logic signed [ac2_pkg::PROD_W-1:0] prod_q;
  logic signed [ac2_pkg::ACC_W-1:0]  mula_q, ta_q, cfa_q;
  ac2_pkg::side_t                    sidea_q;
  logic signed [ac2_pkg::ACC_W-1:0]  acc_q, acc_d, mulb_q, tb_q;
  ac2_pkg::side_t                    sideb_q;
  logic signed [ac2_pkg::PROD_W-1:0] rnd;
  logic signed [ac2_pkg::PROD_W-1:0] scaled;

  // Round half away from zero: floor((p + 2^14 - (p < 0)) / 2^15)
  always_comb begin
    rnd    = prod_q + (prod_q[ac2_pkg::PROD_W-1] ? HALF - 1'b1 : HALF);
    scaled = rnd >>> ac2_pkg::Q_FRAC;
    acc_d  = scaled[ac2_pkg::ACC_W-1:0] + cfa_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= acc_i * mul_i;
      mula_q  <= mul_i;
      ta_q    <= t_i;
      cfa_q   <= coef_i;
      sidea_q <= side_i;
      acc_q   <= acc_d;
      mulb_q  <= mula_q;
      tb_q    <= ta_q;
      sideb_q <= sidea_q;
    end
  end

  assign valid_o = vb_q;
  assign acc_o   = acc_q;
  assign mul_o   = mulb_q;
  assign t_o     = tb_q;
  assign side_o  = sideb_q;

endmodule

// ===== sv/ac2_fold.sv =====
// Tail of the pipeline: scale to the angle format, fold, sign, quadrant fix, saturate.
// Depends on ac2_pkg for formats, pi constants and the side flag struct.
module ac2_fold (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [ac2_pkg::ACC_W-1:0] r_i,
  input  ac2_pkg::side_t                   side_i,
  output logic                             valid_o,
  output logic signed [ac2_pkg::OUT_W-1:0] angle_o
);

  logic                              v1_q, v2_q;
  logic signed [ac2_pkg::ANG_W-1:0]  mag_q, mag_d;
  ac2_pkg::side_t                    side1_q;
  logic signed [ac2_pkg::OUT_W-1:0]  angle_q, angle_d;
  logic [ac2_pkg::ACC_W-2:0]         r_c;
  logic [ac2_pkg::WIDE_W-1:0]        r_w, rs_w;
  logic signed [ac2_pkg::ANG_W-1:0]  rs;
  logic signed [ac2_pkg::ANG_W-1:0]  corr, sum;
  logic signed [ac2_pkg::SAT_W-1:0]  ext;

  // Stage one: move r to the angle format, fold about pi/2
  always_comb begin
    r_c   = r_i[ac2_pkg::ACC_W-1] ? '0 : r_i[ac2_pkg::ACC_W-2:0];
    r_w   = ac2_pkg::WIDE_W'(r_c) + ac2_pkg::R_RND;
    rs_w  = (r_w >> ac2_pkg::SH_R) << ac2_pkg::SH_L;
    rs    = ac2_pkg::ANG_W'(rs_w);
    mag_d = side_i.fold ? ac2_pkg::ANG_HALF_PI - rs : rs;
  end

  // Stage two: sign, +-pi correction for the left half-plane, x = 0 cases, saturation
  always_comb begin
    if (side1_q.x_neg) begin
      corr = side1_q.y_neg ? -ac2_pkg::ANG_PI : ac2_pkg::ANG_PI;
    end else begin
      corr = '0;
    end
    sum = side1_q.neg ? corr - mag_q : corr + mag_q;
    if (side1_q.x_zero) begin
      priority if (side1_q.y_pos) begin
        sum = ac2_pkg::ANG_HALF_PI;
      end else if (side1_q.y_neg) begin
        sum = -ac2_pkg::ANG_HALF_PI;
      end else begin
        sum = '0;
      end
    end
    ext = ac2_pkg::SAT_W'(sum);
    priority if (ext > ac2_pkg::OUT_MAX) begin
      angle_d = ac2_pkg::OUT_W'(ac2_pkg::OUT_MAX);
    end else if (ext < ac2_pkg::OUT_MIN) begin
      angle_d = ac2_pkg::OUT_W'(ac2_pkg::OUT_MIN);
    end else begin
      angle_d = ext[ac2_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      side1_q <= side_i;
      angle_q <= angle_d;
    end
  end

  assign valid_o = v2_q;
  assign angle_o = angle_q;

endmodule

// ===== sv/atan2_polynomial_approx_unit.sv =====
// Four-quadrant fixed-point arc tangent: front stage, divider and polynomial cell chains.
// Depends on ac2_pkg, ac2_div_cell, ac2_mac_cell and ac2_fold.
//
// Usage:
//   Input channel: in_valid_i with y_coord_i / x_coord_i; a transaction is taken at a
//   rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o with angle_o (radians, 13 fraction bits); a transaction
//   completes at a rising edge with out_valid_o high and out_stall_i low.
//   Throughput: one pair per clock while in_stall_o is low. The ratio comes from a
//   chain of 16 division cells (one quotient bit each), the polynomial from 6 multiply
//   cells of 2 stages each. Path: the front register loads at the accepting edge, then
//   the result passes the division cells, the polynomial cells, the fold stages and
//   the output register before it stands on angle_o.
//   Reset clears every valid bit; no transaction is in flight afterwards.
//   Stall: a result waiting on angle_o does not stop the chain; the next finished
//   result parks in a skid register, and only then in_stall_o rises and the whole
//   pipeline holds until the receiver takes the waiting result.
module atan2_polynomial_approx_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ac2_pkg::COORD_BITS-1:0] y_coord_i,
  input  logic signed [ac2_pkg::COORD_BITS-1:0] x_coord_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ac2_pkg::OUT_W-1:0]      angle_o
);

  localparam int MSB = ac2_pkg::COORD_BITS - 1;

  logic                              en;

  // Front stage
  logic [ac2_pkg::MAG_W-1:0]         ay, ax;
  ac2_pkg::side_t                    f_side_d, f_side_q;
  logic                              f_valid_q;
  logic [ac2_pkg::REM_W-1:0]         f_mn_d, f_mn_q;
  logic [ac2_pkg::MAG_W-1:0]         f_mx_d, f_mx_q;

  // Division chain
  logic                              d_valid [ac2_pkg::DIV_N];
  logic [ac2_pkg::REM_W-1:0]         d_rem   [ac2_pkg::DIV_N];
  logic [ac2_pkg::MAG_W-1:0]         d_div   [ac2_pkg::DIV_N];
  logic [ac2_pkg::T_W-1:0]           d_quo   [ac2_pkg::DIV_N];
  ac2_pkg::side_t                    d_side  [ac2_pkg::DIV_N];

  // Polynomial chain
  logic                              m_valid_in [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  m_acc_in   [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  m_mul_in   [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  m_t_in     [ac2_pkg::MAC_N];
  ac2_pkg::side_t                    m_side_in  [ac2_pkg::MAC_N];
  logic                              m_valid    [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  m_acc      [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  m_mul      [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  m_t        [ac2_pkg::MAC_N];
  ac2_pkg::side_t                    m_side     [ac2_pkg::MAC_N];
  logic signed [ac2_pkg::ACC_W-1:0]  t_ratio;

  // Tail and output registers
  logic                              last_valid;
  logic signed [ac2_pkg::OUT_W-1:0]  last_angle;
  logic                              out_valid_q, skid_valid_q, take;
  logic signed [ac2_pkg::OUT_W-1:0]  angle_q, skid_q;

  // Chain advances whenever the skid register is free
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    ay = y_coord_i[MSB] ? ac2_pkg::MAG_W'(-y_coord_i) : ac2_pkg::MAG_W'(y_coord_i);
    ax = x_coord_i[MSB] ? ac2_pkg::MAG_W'(-x_coord_i) : ac2_pkg::MAG_W'(x_coord_i);
    f_side_d.x_zero = x_coord_i == '0;
    f_side_d.y_pos  = !y_coord_i[MSB] && (y_coord_i != '0);
    f_side_d.y_neg  = y_coord_i[MSB];
    f_side_d.x_neg  = x_coord_i[MSB];
    f_side_d.fold   = ay > ax;
    f_side_d.neg    = (y_coord_i != '0) && (y_coord_i[MSB] != x_coord_i[MSB]);
    f_mn_d = ac2_pkg::REM_W'(f_side_d.fold ? ax : ay);
    f_mx_d = f_side_d.fold ? ay : ax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_mn_q   <= f_mn_d;
      f_mx_q   <= f_mx_d;
      f_side_q <= f_side_d;
    end
  end

  for (genvar k = 0; k < ac2_pkg::DIV_N; k++) begin : g_div
    if (k == 0) begin : g_first
      ac2_div_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (f_valid_q),
        .rem_i   (f_mn_q),
        .div_i   (f_mx_q),
        .quo_i   ('0),
        .side_i  (f_side_q),
        .valid_o (d_valid[k]),
        .rem_o   (d_rem[k]),
        .div_o   (d_div[k]),
        .quo_o   (d_quo[k]),
        .side_o  (d_side[k])
      );
    end else begin : g_next
      ac2_div_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (d_valid[k-1]),
        .rem_i   (d_rem[k-1]),
        .div_i   (d_div[k-1]),
        .quo_i   (d_quo[k-1]),
        .side_i  (d_side[k-1]),
        .valid_o (d_valid[k]),
        .rem_o   (d_rem[k]),
        .div_o   (d_div[k]),
        .quo_o   (d_quo[k]),
        .side_o  (d_side[k])
      );
    end
  end

  assign t_ratio = {1'b0, d_quo[ac2_pkg::DIV_N-1]};

  // Cell 0 squares t, cell 1 starts Horner from C4, the last multiplies by t
  for (genvar k = 0; k < ac2_pkg::MAC_N; k++) begin : g_mac
    if (k == 0) begin : g_sq
      assign m_valid_in[k] = d_valid[ac2_pkg::DIV_N-1];
      assign m_acc_in[k]   = t_ratio;
      assign m_mul_in[k]   = t_ratio;
      assign m_t_in[k]     = t_ratio;
      assign m_side_in[k]  = d_side[ac2_pkg::DIV_N-1];
    end else if (k == 1) begin : g_start
      assign m_valid_in[k] = m_valid[k-1];
      assign m_acc_in[k]   = ac2_pkg::C4;
      assign m_mul_in[k]   = m_acc[k-1];
      assign m_t_in[k]     = m_t[k-1];
      assign m_side_in[k]  = m_side[k-1];
    end else if (k == ac2_pkg::MAC_N - 1) begin : g_last
      assign m_valid_in[k] = m_valid[k-1];
      assign m_acc_in[k]   = m_acc[k-1];
      assign m_mul_in[k]   = m_t[k-1];
      assign m_t_in[k]     = m_t[k-1];
      assign m_side_in[k]  = m_side[k-1];
    end else begin : g_horner
      assign m_valid_in[k] = m_valid[k-1];
      assign m_acc_in[k]   = m_acc[k-1];
      assign m_mul_in[k]   = m_mul[k-1];
      assign m_t_in[k]     = m_t[k-1];
      assign m_side_in[k]  = m_side[k-1];
    end

    ac2_mac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (m_valid_in[k]),
      .acc_i   (m_acc_in[k]),
      .mul_i   (m_mul_in[k]),
      .t_i     (m_t_in[k]),
      .coef_i  (ac2_pkg::MAC_COEF[k]),
      .side_i  (m_side_in[k]),
      .valid_o (m_valid[k]),
      .acc_o   (m_acc[k]),
      .mul_o   (m_mul[k]),
      .t_o     (m_t[k]),
      .side_o  (m_side[k])
    );
  end

  ac2_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid[ac2_pkg::MAC_N-1]),
    .r_i     (m_acc[ac2_pkg::MAC_N-1]),
    .side_i  (m_side[ac2_pkg::MAC_N-1]),
    .valid_o (last_valid),
    .angle_o (last_angle)
  );

  // Output register with skid: park one result while the receiver stalls
  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (last_valid) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        angle_q <= skid_q;
      end
    end else if (last_valid) begin
      if (out_valid_q && !take) begin
        skid_q <= last_angle;
      end else begin
        angle_q <= last_angle;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_valid_q && last_valid && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("finished result dropped while the output was stalled");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && out_valid_q
      && angle_q == $past(skid_q)))
    else $error("skid register not moved to the output when taken");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_o <= ac2_pkg::ANGLE_MAX && angle_o >= ac2_pkg::ANGLE_MIN))
    else $error("angle outside the range of -pi to pi");

endmodule
